// ===== rtl/ssca_pkg.sv =====
package ssca_pkg;

  localparam int POOL_PAGES     = 64;
  localparam int PAGE_BYTES     = 4096;
  localparam int HEADER_BYTES   = 32;
  localparam int SLOTS_PER_PAGE = 512;
  localparam int NUM_CLASSES    = 9;
  localparam int MIN_STRIDE     = 8;

  localparam int PG_W      = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int PGL_W     = PG_W + 1;
  localparam int SLOT_W    = $clog2(SLOTS_PER_PAGE);
  localparam int OFF_W     = $clog2(PAGE_BYTES);
  localparam int CLS_W     = 4;
  localparam int STRIDE_SH = $clog2(MIN_STRIDE);
  localparam int LINK_AW   = PG_W + SLOT_W;
  localparam int GRP       = 8;
  localparam int GRP_W     = $clog2(GRP);
  localparam int NGRP      = (POOL_PAGES + GRP - 1) / GRP;
  localparam int PAD_W     = NGRP * GRP;
  localparam int CFG_AW    = 3;

  localparam logic [PGL_W-1:0] PAGE_NIL = {PGL_W{1'b1}};
  localparam logic             CMD_ALLOC = 1'b0;
  localparam logic             CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_LARGE = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic [SLOT_W-1:0] used;
    logic [SLOT_W-1:0] head;
  } page_info_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_SCAN, S_THREAD, S_AWAIT, S_RLINK, S_LWAIT,
    S_FWAIT, S_FCHK, S_RM1, S_RM2, S_PUSH1, S_PUSH2, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD, DP_SCAN, DP_RESULT, DP_CLAIM, DP_THREAD, DP_RD_INFO,
    DP_LD_INFO, DP_UPD_ALLOC, DP_UPD_FREE, DP_RM_WR, DP_PUSH1, DP_PUSH2, DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic null_free;
    logic pre_bad;
    logic too_large;
    logic hd_valid;
    logic none_free;
    logic thread_last;
    logic free_bad;
    logic full_new;
    logic in_list;
    logic used_zero;
    logic last_obj;
    logic out_free;
  } stat_t;

  // smallest class whose stride holds the size; NUM_CLASSES when too large
  function automatic logic [CLS_W-1:0] size_class(input logic [15:0] size);
    logic [16:0]      s;
    logic [CLS_W-1:0] c;
    s = (size == 16'd0) ? 17'd1 : {1'b0, size};
    c = CLS_W'(NUM_CLASSES);
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (s <= (17'(MIN_STRIDE) << k)) c = CLS_W'(k);
    end
    return c;
  endfunction

  function automatic logic [SLOT_W:0] objects_of(input logic [CLS_W-1:0] cls);
    int n;
    n = (PAGE_BYTES - HEADER_BYTES) >> (int'(cls) + STRIDE_SH);
    if (int'(cls) >= NUM_CLASSES) n = 0;
    if (n > SLOTS_PER_PAGE) n = SLOTS_PER_PAGE;
    return (SLOT_W + 1)'(n);
  endfunction

endpackage

// ===== rtl/ssca_ram.sv =====
module ssca_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/ssca_ctrl.sv =====
module ssca_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  ssca_pkg::stat_t stat,
  output logic           in_ready,
  output ssca_pkg::cmd_t cmd
);
  import ssca_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    cmd.code  = ST_OK;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.is_free) begin
          if (stat.null_free) begin
            state_nxt = S_OUT;
          end else if (stat.pre_bad) begin
            cmd.op    = DP_RESULT;
            cmd.code  = ST_BAD;
            state_nxt = S_OUT;
          end else begin
            cmd.op    = DP_RD_INFO;
            state_nxt = S_FWAIT;
          end
        end else if (stat.too_large) begin
          cmd.op    = DP_RESULT;
          cmd.code  = ST_LARGE;
          state_nxt = S_OUT;
        end else if (stat.hd_valid) begin
          cmd.op    = DP_RD_INFO;
          state_nxt = S_AWAIT;
        end else begin
          cmd.op    = DP_SCAN;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.none_free) begin
          cmd.op    = DP_RESULT;
          cmd.code  = ST_OOM;
          state_nxt = S_OUT;
        end else begin
          cmd.op    = DP_CLAIM;
          state_nxt = S_THREAD;
        end
      end
      S_THREAD: begin
        cmd.op = DP_THREAD;
        if (stat.thread_last) state_nxt = S_RLINK;
      end
      S_AWAIT: begin
        cmd.op    = DP_LD_INFO;
        state_nxt = S_RLINK;
      end
      S_RLINK: state_nxt = S_LWAIT;
      S_LWAIT: begin
        cmd.op = DP_UPD_ALLOC;
        if (stat.full_new && stat.in_list)        state_nxt = S_RM1;
        else if (!stat.full_new && !stat.in_list) state_nxt = S_PUSH1;
        else                                      state_nxt = S_OUT;
      end
      S_FWAIT: begin
        cmd.op    = DP_LD_INFO;
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (stat.free_bad) begin
          cmd.op    = DP_RESULT;
          cmd.code  = ST_BAD;
          state_nxt = S_OUT;
        end else begin
          cmd.op = DP_UPD_FREE;
          if (stat.in_list)       state_nxt = S_RM1;
          else if (stat.last_obj) state_nxt = S_OUT;
          else                    state_nxt = S_PUSH1;
        end
      end
      S_RM1: state_nxt = S_RM2;
      S_RM2: begin
        cmd.op = DP_RM_WR;
        if (stat.is_free && !stat.used_zero) state_nxt = S_PUSH1;
        else                                 state_nxt = S_OUT;
      end
      S_PUSH1: begin
        cmd.op    = DP_PUSH1;
        state_nxt = S_PUSH2;
      end
      S_PUSH2: begin
        cmd.op    = DP_PUSH2;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op    = DP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/ssca_dp.sv =====
module ssca_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  ssca_pkg::cmd_t  cmd,
  input  logic [31:0]     pool_base,
  input  logic            in_command,
  input  logic [15:0]     in_request_size,
  input  logic [31:0]     in_object_address,
  input  logic            out_ready,
  output logic            out_valid,
  output logic [31:0]     out_granted_address,
  output logic [1:0]      out_status,
  output ssca_pkg::stat_t stat
);
  import ssca_pkg::*;

  // request and working registers
  logic                req_cmd_r;
  logic [15:0]         req_size_r;
  logic [31:0]         req_addr_r;
  logic [PG_W-1:0]     pg_r;
  page_info_t          info_r;
  logic [SLOT_W-1:0]   thr_r;
  logic [NGRP-1:0]     grp_any_r;
  logic [GRP_W-1:0]    grp_low_r [NGRP];
  logic [PGL_W-1:0]    push_nxt_r;
  logic [31:0]         res_addr_r;
  status_t             res_status_r;
  logic                out_valid_r;
  logic [31:0]         out_addr_r;
  status_t             out_status_r;
  logic [POOL_PAGES-1:0] free_map_r;
  logic [POOL_PAGES-1:0] in_list_r;
  logic [PGL_W-1:0]    head_r [NUM_CLASSES];

  // RAM ports
  logic                info_we;
  logic [PG_W-1:0]     info_waddr, info_raddr;
  page_info_t          info_wdata, info_rdata;
  logic                next_we, prev_we;
  logic [PG_W-1:0]     next_waddr, prev_waddr;
  logic [PGL_W-1:0]    next_wdata, prev_wdata, next_rdata, prev_rdata;
  logic                link_we;
  logic [LINK_AW-1:0]  link_waddr, link_raddr;
  logic [SLOT_W-1:0]   link_wdata, link_rdata;

  // decode
  logic [CLS_W-1:0]    cls_sz;
  logic [PGL_W-1:0]    hd;
  logic [31:0]         diff;
  logic [PG_W-1:0]     fpg;
  logic                fpg_ok;
  logic [OFF_W-1:0]    off, off_rel, fidx_full;
  logic [SLOT_W:0]     n_cur;
  logic [SLOT_W-1:0]   fidx;
  logic [SLOT_W-1:0]   used_inc, used_dec;
  logic [PAD_W-1:0]    free_pad;
  logic [PG_W-1:0]     scan_pg;
  logic [PG_W-1:0]     rd_pg;
  logic [PGL_W-1:0]    rm_prv, rm_nxt;
  logic [SLOT_W:0]     thr_inc;
  logic [31:0]         alloc_addr;

  assign cls_sz    = size_class(req_size_r);
  assign hd        = (int'(cls_sz) < NUM_CLASSES) ? head_r[cls_sz] : PAGE_NIL;
  assign diff      = req_addr_r - pool_base;
  assign fpg_ok    = diff[31:OFF_W] < (32 - OFF_W)'(POOL_PAGES);
  assign fpg       = diff[OFF_W+PG_W-1:OFF_W];
  assign off       = diff[OFF_W-1:0];
  assign off_rel   = off - OFF_W'(HEADER_BYTES);
  assign fidx_full = off_rel >> ({1'b0, info_r.cls} + 5'(STRIDE_SH));
  assign fidx      = fidx_full[SLOT_W-1:0];
  assign n_cur     = objects_of(info_r.cls);
  assign used_inc  = info_r.used + 1'b1;
  assign used_dec  = info_r.used - 1'b1;
  assign thr_inc   = {1'b0, thr_r} + 1'b1;
  assign free_pad  = PAD_W'(free_map_r);
  assign rd_pg     = req_cmd_r ? fpg : hd[PG_W-1:0];
  assign rm_prv    = prev_rdata;
  assign rm_nxt    = next_rdata;
  assign alloc_addr = pool_base
                    + {{(32-PG_W-OFF_W){1'b0}}, pg_r, {OFF_W{1'b0}}}
                    + 32'(HEADER_BYTES)
                    + (32'(info_r.head) << ({1'b0, info_r.cls} + 5'(STRIDE_SH)));

  // lowest group holding a free page
  always_comb begin
    scan_pg = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) scan_pg = PG_W'({g[PG_W-1:0], grp_low_r[g]});
    end
  end

  always_comb begin
    stat.is_free     = req_cmd_r == CMD_FREE;
    stat.null_free   = req_addr_r == 32'd0;
    stat.pre_bad     = !fpg_ok || free_map_r[fpg];
    stat.too_large   = int'(cls_sz) >= NUM_CLASSES;
    stat.hd_valid    = hd < PGL_W'(POOL_PAGES);
    stat.none_free   = !(|grp_any_r);
    stat.thread_last = thr_inc == n_cur;
    stat.free_bad    = (info_r.used == '0) || (off < OFF_W'(HEADER_BYTES))
                     || (fidx_full >= OFF_W'(n_cur));
    stat.full_new    = {1'b0, used_inc} >= n_cur;
    stat.in_list     = in_list_r[pg_r];
    stat.used_zero   = info_r.used == '0;
    stat.last_obj    = info_r.used == SLOT_W'(1);
    stat.out_free    = !out_valid_r || out_ready;
  end

  // RAM write steering
  always_comb begin
    info_we    = 1'b0;
    info_waddr = pg_r;
    info_wdata = info_r;
    info_raddr = rd_pg;
    next_we    = 1'b0;
    next_waddr = pg_r;
    next_wdata = PAGE_NIL;
    prev_we    = 1'b0;
    prev_waddr = pg_r;
    prev_wdata = PAGE_NIL;
    link_we    = 1'b0;
    link_waddr = {pg_r, thr_r};
    link_wdata = (thr_inc < n_cur) ? thr_inc[SLOT_W-1:0] : '0;
    link_raddr = {pg_r, info_r.head};
    case (cmd.op)
      DP_CLAIM: begin
        info_we    = 1'b1;
        info_waddr = scan_pg;
        info_wdata = '{cls: cls_sz, used: '0, head: '0};
      end
      DP_THREAD: link_we = 1'b1;
      DP_UPD_ALLOC: begin
        info_we    = 1'b1;
        info_wdata = '{cls: info_r.cls, used: used_inc, head: link_rdata};
      end
      DP_UPD_FREE: begin
        info_we    = 1'b1;
        info_wdata = '{cls: info_r.cls, used: used_dec, head: fidx};
        link_we    = 1'b1;
        link_waddr = {pg_r, fidx};
        link_wdata = info_r.head;
      end
      DP_RM_WR: begin
        if (rm_prv != PAGE_NIL && rm_prv < PGL_W'(POOL_PAGES)) begin
          next_we    = 1'b1;
          next_waddr = rm_prv[PG_W-1:0];
          next_wdata = rm_nxt;
        end
        if (rm_nxt < PGL_W'(POOL_PAGES)) begin
          prev_we    = 1'b1;
          prev_waddr = rm_nxt[PG_W-1:0];
          prev_wdata = rm_prv;
        end
      end
      DP_PUSH1: begin
        next_we    = 1'b1;
        next_wdata = head_r[info_r.cls];
        prev_we    = 1'b1;
        prev_wdata = PAGE_NIL;
      end
      DP_PUSH2: begin
        if (push_nxt_r < PGL_W'(POOL_PAGES)) begin
          prev_we    = 1'b1;
          prev_waddr = push_nxt_r[PG_W-1:0];
          prev_wdata = {1'b0, pg_r};
        end
      end
      default: ;
    endcase
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        req_cmd_r    <= in_command;
        req_size_r   <= in_request_size;
        req_addr_r   <= in_object_address;
        res_addr_r   <= '0;
        res_status_r <= ST_OK;
      end
      DP_SCAN: begin
        for (int g = 0; g < NGRP; g++) begin
          grp_any_r[g] <= |free_pad[g*GRP +: GRP];
          grp_low_r[g] <= '0;
          for (int b = GRP - 1; b >= 0; b--) begin
            if (free_pad[g*GRP + b]) grp_low_r[g] <= GRP_W'(b);
          end
        end
      end
      DP_RESULT: res_status_r <= cmd.code;
      DP_CLAIM: begin
        pg_r   <= scan_pg;
        info_r <= '{cls: cls_sz, used: '0, head: '0};
        thr_r  <= '0;
      end
      DP_THREAD:    thr_r  <= thr_inc[SLOT_W-1:0];
      DP_RD_INFO:   pg_r   <= rd_pg;
      DP_LD_INFO:   info_r <= info_rdata;
      DP_UPD_ALLOC: begin
        info_r     <= '{cls: info_r.cls, used: used_inc, head: link_rdata};
        res_addr_r <= alloc_addr;
      end
      DP_UPD_FREE:  info_r <= '{cls: info_r.cls, used: used_dec, head: fidx};
      DP_PUSH1:     push_nxt_r <= head_r[info_r.cls];
      DP_OUT: begin
        out_addr_r   <= res_addr_r;
        out_status_r <= res_status_r;
      end
      default: ;
    endcase
  end

  // control state: page maps, list heads, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_map_r  <= '1;
      in_list_r   <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) head_r[c] <= PAGE_NIL;
    end else begin
      if (cmd.op == DP_OUT)  out_valid_r <= 1'b1;
      else if (out_ready)    out_valid_r <= 1'b0;
      case (cmd.op)
        DP_CLAIM: begin
          free_map_r[scan_pg] <= 1'b0;
          in_list_r[scan_pg]  <= 1'b0;
        end
        DP_UPD_FREE: if (stat.last_obj) free_map_r[pg_r] <= 1'b1;
        DP_RM_WR: begin
          if (rm_prv == PAGE_NIL) head_r[info_r.cls] <= rm_nxt;
          in_list_r[pg_r] <= 1'b0;
        end
        DP_PUSH1: begin
          head_r[info_r.cls] <= {1'b0, pg_r};
          in_list_r[pg_r]    <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  ssca_ram #(.W($bits(page_info_t)), .D(POOL_PAGES)) u_info (
    .clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
    .raddr(info_raddr), .rdata(info_rdata)
  );
  ssca_ram #(.W(PGL_W), .D(POOL_PAGES)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(pg_r), .rdata(next_rdata)
  );
  ssca_ram #(.W(PGL_W), .D(POOL_PAGES)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(pg_r), .rdata(prev_rdata)
  );
  ssca_ram #(.W(SLOT_W), .D(POOL_PAGES * SLOTS_PER_PAGE)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_status          = out_status_r;
endmodule

// ===== rtl/slab_size_class_allocator.sv =====
// Slab allocator over a pool of 4 KiB pages with nine power-of-two size
// classes (8 to 2048 bytes).
// Input channel (in_valid/in_ready): one request word - command (0 alloc,
// 1 free), request_size for alloc, object_address for free. Result channel
// (out_valid/out_ready): granted_address and status (ok, out of pages,
// too large, bad free). Exactly one result word per request.
// pool_base is written over the APB port at byte address 0; the user must
// do so only while idle, as the block itself does not enforce it. One
// request at a time; the controller steps through the page metadata, list
// and object link RAMs, each read being registered. An alloc that claims a
// fresh page also threads that page's free list one link a cycle, writing
// 4064/stride links (508 for the 8-byte class).
// in_ready is high only while idle. A result waits in the output register
// while out_ready is low; the next request is still accepted, and its result
// holds the block until the previous one is taken.
// Reset (synchronous, active low) marks every page free, clears the partial
// lists and the output valid, and sets pool_base to zero. No clearing pass.
module slab_size_class_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_command,
  input  logic [15:0]                 in_request_size,
  input  logic [31:0]                 in_object_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 out_granted_address,
  output logic [1:0]                  out_status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssca_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ssca_pkg::*;

  logic [31:0] pool_base_r;
  cmd_t        cmd;
  stat_t       stat;

  assign pready = 1'b1;
  assign prdata = (paddr == '0) ? pool_base_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= '0;
    end else if (psel && penable && pwrite && paddr == '0) begin
      pool_base_r <= pwdata;
    end
  end

  ssca_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .stat(stat),
    .in_ready(in_ready), .cmd(cmd)
  );

  ssca_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .pool_base(pool_base_r),
    .in_command(in_command), .in_request_size(in_request_size),
    .in_object_address(in_object_address), .out_ready(out_ready),
    .out_valid(out_valid), .out_granted_address(out_granted_address),
    .out_status(out_status), .stat(stat)
  );
endmodule

// ===== rtl/ssca_chk.sv =====
module ssca_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_command,
  input logic [15:0]                 in_request_size,
  input logic [31:0]                 in_object_address,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [31:0]                 out_granted_address,
  input logic [1:0]                  out_status,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [ssca_pkg::CFG_AW-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata,
  input logic                        pready
);
  import ssca_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_granted_address)
                                && $stable(out_status))
    else $error("result word changed while stalled");

  // only a successful alloc carries an address
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_granted_address == 32'd0)
    else $error("address on a failed result");

  // one request in flight: busy straight after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second word while busy");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind slab_size_class_allocator ssca_chk u_chk (.*);
